[sv/alle_pkg.sv]
package alle_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_BITS  = 6;
  localparam int VALUE_BITS = 32;
  localparam int GRP_SIZE   = 8;
  localparam int GRP_CNT    = SLOTS / GRP_SIZE;
  localparam int GRP_BITS   = 3;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // reply status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef logic [SLOT_BITS-1:0] slot_t;

  typedef struct packed {
    logic                         kind;
    slot_t                        slot_index;
    logic signed [VALUE_BITS-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    slot_t      used_slot;
    slot_t      head_slot;
    slot_t      tail_slot;
    slot_t      live_count;
  } out_item_t;

  // lowest free slot search result
  typedef struct packed {
    logic  found;
    slot_t slot;
  } free_res_t;

endpackage

[sv/array_linked_list_engine.sv]
// Doubly linked list kept in 64 fixed slots; slot 0 is the sentinel.
// Input channel (in_valid/in_stall/in_data): one request per transfer, either
// insert item_value after slot_index (0 = front) or delete slot_index.
// Output channel (out_valid/out_stall/out_data): exactly one reply per request
// with status, the slot used, and head, tail and live count after the request.
// Steps from input transfer to reply registered at the output: an insert
// passes S_READ and S_LINK, a delete S_READ, a bad-slot reject S_RESP, and a
// full-list reject S_READ. One request is worked at a time; in_stall stays
// high from the transfer until the reply is loaded into the output register,
// so no new request is taken before the last one is through. The link
// memories each have one write port, and an insert writes two entries of each.
// Free slots: two-stage search over in-use bits; only stage 1 is registered.
// Reset (rst_n low, synchronous) empties the list: all slots free, head, tail
// and count zero. Link and value memories are not cleared; data read from a
// free slot is never used.
// If the receiver stalls, the reply waits in the output register. A request
// finishing while the register is still full holds its last step, commits
// nothing more, and completes once the register frees up.
module array_linked_list_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  alle_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output alle_pkg::out_item_t  out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_READ = 2'd1;  // link read data available
  localparam logic [1:0] S_LINK = 2'd2;  // insert: splice into neighbors
  localparam logic [1:0] S_RESP = 2'd3;  // rejected request: send reply

  // control state
  logic [1:0]                 state_r, state_nxt;
  logic [alle_pkg::SLOTS-1:0] in_use_r, in_use_nxt;
  alle_pkg::slot_t            head_r, head_nxt;
  alle_pkg::slot_t            tail_r, tail_nxt;
  alle_pkg::slot_t            count_r, count_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // request payload
  logic                              kind_r, kind_nxt;
  alle_pkg::slot_t                   slot_r, slot_nxt;
  logic [alle_pkg::VALUE_BITS-1:0]   value_r, value_nxt;
  alle_pkg::slot_t                   fresh_r, fresh_nxt;
  alle_pkg::slot_t                   after_r, after_nxt;
  logic [1:0]                        err_r, err_nxt;
  alle_pkg::out_item_t               out_data_r, out_data_nxt;

  logic            accept;
  logic            out_free;
  logic            slot_live;
  alle_pkg::slot_t rd_addr;
  alle_pkg::slot_t after_w;

  // memory ports
  logic                            nxt_we, prv_we, val_we;
  alle_pkg::slot_t                 nxt_wa, prv_wa;
  alle_pkg::slot_t                 nxt_wd, prv_wd;
  alle_pkg::slot_t                 nxt_rd, prv_rd;
  alle_pkg::free_res_t             free_res;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign slot_live = in_use_r[in_data.slot_index];
  // hold the read address on the latched slot so read data stays put
  assign rd_addr   = (state_r == S_IDLE) ? in_data.slot_index : slot_r;
  assign after_w   = (slot_r == '0) ? head_r : nxt_rd;

  alle_ram #(.WIDTH(alle_pkg::SLOT_BITS), .DEPTH(alle_pkg::SLOTS)) u_next_ram (
    .clk     (clk),
    .wr_en   (nxt_we),
    .wr_addr (nxt_wa),
    .wr_data (nxt_wd),
    .rd_addr (rd_addr),
    .rd_data (nxt_rd)
  );

  alle_ram #(.WIDTH(alle_pkg::SLOT_BITS), .DEPTH(alle_pkg::SLOTS)) u_prev_ram (
    .clk     (clk),
    .wr_en   (prv_we),
    .wr_addr (prv_wa),
    .wr_data (prv_wd),
    .rd_addr (rd_addr),
    .rd_data (prv_rd)
  );

  // value store is write-only inside the block
  alle_ram #(.WIDTH(alle_pkg::VALUE_BITS), .DEPTH(alle_pkg::SLOTS)) u_value_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (fresh_nxt),
    .wr_data (value_r),
    .rd_addr (fresh_r),
    .rd_data ()
  );

  alle_free_find u_free_find (
    .clk    (clk),
    .load   (accept),
    .in_use (in_use_r),
    .res    (free_res)
  );

  always_comb begin
    state_nxt     = state_r;
    in_use_nxt    = in_use_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    value_nxt     = value_r;
    fresh_nxt     = fresh_r;
    after_nxt     = after_r;
    err_nxt       = err_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    nxt_we        = 1'b0;
    nxt_wa        = '0;
    nxt_wd        = '0;
    prv_we        = 1'b0;
    prv_wa        = '0;
    prv_wd        = '0;
    val_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_data.kind;
          slot_nxt  = in_data.slot_index;
          value_nxt = in_data.item_value;
          err_nxt   = alle_pkg::ST_BAD_SLOT;
          if (in_data.kind == alle_pkg::KIND_INSERT) begin
            state_nxt = (in_data.slot_index == '0 || slot_live) ? S_READ : S_RESP;
          end else begin
            state_nxt = (in_data.slot_index != '0 && slot_live) ? S_READ : S_RESP;
          end
        end
      end

      S_READ: begin
        if (kind_r == alle_pkg::KIND_INSERT) begin
          if (!free_res.found) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{alle_pkg::ST_FULL, '0, head_r, tail_r, count_r};
              state_nxt     = S_IDLE;
            end
          end else begin
            // new slot's own links and value
            fresh_nxt = free_res.slot;
            after_nxt = after_w;
            nxt_we    = 1'b1;
            nxt_wa    = free_res.slot;
            nxt_wd    = after_w;
            prv_we    = 1'b1;
            prv_wa    = free_res.slot;
            prv_wd    = slot_r;
            val_we    = 1'b1;
            state_nxt = S_LINK;
          end
        end else if (out_free) begin
          // delete: prv_rd / nxt_rd hold the neighbors
          if (prv_rd == '0) begin
            head_nxt = nxt_rd;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd;
            nxt_wd = nxt_rd;
          end
          if (nxt_rd == '0) begin
            tail_nxt = prv_rd;
          end else begin
            prv_we = 1'b1;
            prv_wa = nxt_rd;
            prv_wd = prv_rd;
          end
          in_use_nxt[slot_r] = 1'b0;
          count_nxt          = count_r - 1'b1;
          out_valid_nxt      = 1'b1;
          out_data_nxt       = '{alle_pkg::ST_OK, slot_r, head_nxt, tail_nxt, count_nxt};
          state_nxt          = S_IDLE;
        end
      end

      S_LINK: begin
        if (out_free) begin
          if (slot_r == '0) begin
            head_nxt = fresh_r;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = slot_r;
            nxt_wd = fresh_r;
          end
          if (after_r == '0) begin
            tail_nxt = fresh_r;
          end else begin
            prv_we = 1'b1;
            prv_wa = after_r;
            prv_wd = fresh_r;
          end
          in_use_nxt[fresh_r] = 1'b1;
          count_nxt           = count_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_data_nxt        = '{alle_pkg::ST_OK, fresh_r, head_nxt, tail_nxt, count_nxt};
          state_nxt           = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{err_r, '0, head_r, tail_r, count_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    value_r    <= value_nxt;
    fresh_r    <= fresh_nxt;
    after_r    <= after_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/alle_ram.sv]
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/alle_free_find.sv]
module alle_free_find (
  input  logic                          clk,
  input  logic                          load,
  input  logic [alle_pkg::SLOTS-1:0]    in_use,
  output alle_pkg::free_res_t           res
);

  logic [alle_pkg::SLOTS-1:0]    free_vec;
  logic [alle_pkg::GRP_CNT-1:0]  grp_any_r;
  logic [alle_pkg::GRP_BITS-1:0] grp_idx_r [alle_pkg::GRP_CNT];

  function automatic logic [alle_pkg::GRP_BITS-1:0] low_idx(
    input logic [alle_pkg::GRP_SIZE-1:0] bits
  );
    logic [alle_pkg::GRP_BITS-1:0] idx;
    idx = '0;
    for (int i = alle_pkg::GRP_SIZE - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = alle_pkg::GRP_BITS'(i);
      end
    end
    return idx;
  endfunction

  // slot 0 is the sentinel and never allocated
  always_comb begin
    free_vec    = ~in_use;
    free_vec[0] = 1'b0;
  end

  // stage 1: per-group encode, registered
  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < alle_pkg::GRP_CNT; g++) begin
        grp_any_r[g] <= |free_vec[g*alle_pkg::GRP_SIZE +: alle_pkg::GRP_SIZE];
        grp_idx_r[g] <= low_idx(free_vec[g*alle_pkg::GRP_SIZE +: alle_pkg::GRP_SIZE]);
      end
    end
  end

  // stage 2: pick the lowest group with a free slot
  always_comb begin
    res = '0;
    for (int g = alle_pkg::GRP_CNT - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        res.found = 1'b1;
        res.slot  = {alle_pkg::GRP_BITS'(g), grp_idx_r[g]};
      end
    end
  end

endmodule

[sim/list_reply_checker.sv]
module list_reply_checker
  import alle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        pending,
  output int        errors
);

  // shadow of the list structure; values never show up in a reply
  logic [SLOTS-1:0] live_mask;
  slot_t            fwd_link  [SLOTS];
  slot_t            back_link [SLOTS];
  slot_t            head_ptr;
  slot_t            tail_ptr;
  slot_t            elem_count;

  out_item_t        replies_due [$];
  out_item_t        want;

  initial errors = 0;

  task automatic flag(input string what, input int got, input int exp_v);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_v, $time);
    errors++;
  endtask

  function automatic out_item_t apply_request(input in_item_t r);
    out_item_t res;
    slot_t     s;
    slot_t     fresh;
    slot_t     after_s;
    slot_t     p;
    slot_t     n;
    s = r.slot_index;
    res = '0;
    res.status = ST_OK;
    if (r.kind == KIND_INSERT) begin
      fresh = '0;
      for (int i = SLOTS - 1; i >= 1; i--) begin
        if (!live_mask[i]) fresh = slot_t'(i);
      end
      if (s != 0 && !live_mask[s]) begin
        res.status = ST_BAD_SLOT;
      end else if (fresh == 0) begin
        res.status = ST_FULL;
      end else begin
        after_s = (s == 0) ? head_ptr : fwd_link[s];
        live_mask[fresh] = 1'b1;
        back_link[fresh] = s;
        fwd_link[fresh]  = after_s;
        if (after_s == 0) tail_ptr = fresh;
        else back_link[after_s] = fresh;
        if (s == 0) head_ptr = fresh;
        else fwd_link[s] = fresh;
        elem_count++;
        res.used_slot = fresh;
      end
    end else begin
      if (s == 0 || !live_mask[s]) begin
        res.status = ST_BAD_SLOT;
      end else begin
        p = back_link[s];
        n = fwd_link[s];
        if (p == 0) head_ptr = n;
        else fwd_link[p] = n;
        if (n == 0) tail_ptr = p;
        else back_link[n] = p;
        live_mask[s] = 1'b0;
        fwd_link[s]  = '0;
        back_link[s] = '0;
        if (elem_count > 0) elem_count--;
        res.used_slot = s;
      end
    end
    res.head_slot  = head_ptr;
    res.tail_slot  = tail_ptr;
    res.live_count = elem_count;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      live_mask  = '0;
      head_ptr   = '0;
      tail_ptr   = '0;
      elem_count = '0;
      for (int i = 0; i < SLOTS; i++) begin
        fwd_link[i]  = '0;
        back_link[i] = '0;
      end
      replies_due.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) replies_due.push_back(apply_request(in_data));
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag("reply with no request outstanding, used_slot", out_data.used_slot, 0);
        end else begin
          want = replies_due.pop_front();
          if (out_data.status !== want.status)
            flag("status", out_data.status, want.status);
          if (out_data.used_slot !== want.used_slot)
            flag("used_slot", out_data.used_slot, want.used_slot);
          if (out_data.head_slot !== want.head_slot)
            flag("head_slot", out_data.head_slot, want.head_slot);
          if (out_data.tail_slot !== want.tail_slot)
            flag("tail_slot", out_data.tail_slot, want.tail_slot);
          if (out_data.live_count !== want.live_count)
            flag("live_count", out_data.live_count, want.live_count);
        end
      end
      pending <= replies_due.size();
    end
  end

endmodule

[sim/array_linked_list_engine_test.sv]
module array_linked_list_engine_test;
  import alle_pkg::*;

  localparam int RANDOM_ITEMS = 1900;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int        pending;
  int        errors;

  // stretches with no idling on either side
  bit        quiet_tx  = 1'b0;
  bit        quiet_rx  = 1'b0;

  // slots the stimulus believes are live; used only to aim requests at
  // real elements so the list gets deep, never to judge replies
  logic [SLOTS-1:0] occupied = '0;

  array_linked_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  list_reply_checker reply_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. The slowest legal run, with the longest sender idle gaps and
  // receiver stalls, takes roughly 0.95M time units; this is ~8x that.
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t mk_req(input logic k, input slot_t s,
                                      input logic signed [31:0] v);
    in_item_t r;
    r.kind       = k;
    r.slot_index = s;
    r.item_value = v;
    return r;
  endfunction

  // One request transfer: optional idle gap, then hold valid and payload
  // until the block takes it. Valid is only written once per edge, so
  // back to back transfers keep it high.
  task automatic send(input in_item_t req);
    int    gap;
    slot_t fresh;
    gap = quiet_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    // keep the occupancy picture in step with what was just taken
    fresh = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (!occupied[i]) fresh = slot_t'(i);
    end
    if (req.kind == KIND_INSERT) begin
      if ((req.slot_index == 0 || occupied[req.slot_index]) && fresh != 0)
        occupied[fresh] = 1'b1;
    end else if (req.slot_index != 0) begin
      occupied[req.slot_index] = 1'b0;
    end
  endtask

  // Receiver: stall for a random number of cycles ahead of each reply,
  // then drop stall until one transfer happens.
  initial begin
    int n;
    forever begin
      if ($urandom_range(0, 59) == 0) quiet_rx = ~quiet_rx;
      n = quiet_rx ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int    grow_pct;
    int    idx;
    int    live_cnt;
    slot_t live_list [$];
    slot_t s;
    logic  k;

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // rejects on an empty list: sentinel delete, delete of a free slot,
    // insert after a free slot
    send(mk_req(KIND_DELETE, 6'd0, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd5, 32'sd0));
    send(mk_req(KIND_INSERT, 6'd7, 32'sd0));
    // front insert into the empty list, then remove the sole element
    send(mk_req(KIND_INSERT, 6'd0, 32'sh7FFFFFFF));
    send(mk_req(KIND_DELETE, 6'd1, 32'sd0));
    // build 3 -> 4 -> 1 -> 2 -> 5: front insert on a non-empty list,
    // insert mid-list and at the tail
    send(mk_req(KIND_INSERT, 6'd0, 32'sh80000000));
    send(mk_req(KIND_INSERT, 6'd1, 32'sd0));
    send(mk_req(KIND_INSERT, 6'd0, -32'sd1));
    send(mk_req(KIND_INSERT, 6'd3, 32'sd1));
    send(mk_req(KIND_INSERT, 6'd2, 32'sh55555555));
    // unlink from the middle, the head and the tail
    send(mk_req(KIND_DELETE, 6'd4, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd3, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd5, 32'sd0));
    // highest index, free: both operations rejected
    send(mk_req(KIND_INSERT, 6'd63, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd63, 32'shFFFFFFFF));
    // lowest free slot gets reused
    send(mk_req(KIND_INSERT, 6'd0, 32'shAAAAAAAA));
    send(mk_req(KIND_DELETE, 6'd1, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd2, 32'sd0));
    send(mk_req(KIND_DELETE, 6'd3, 32'sd0));

    // --- random part ---
    // Phases swing the list between empty and full so full-list rejects
    // and long link chains both get exercised. One request in ten is
    // noise with any kind and any slot.
    grow_pct = 85;
    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      if ($urandom_range(0, 59) == 0) quiet_tx = ~quiet_tx;
      live_list.delete();
      for (int i = 1; i < SLOTS; i++) begin
        if (occupied[i]) live_list.push_back(slot_t'(i));
      end
      live_cnt = live_list.size();
      if (live_cnt == SLOTS - 1 && $urandom_range(0, 7) == 0) grow_pct = 15;
      if (live_cnt == 0 && $urandom_range(0, 3) == 0) grow_pct = 85;
      if ($urandom_range(0, 199) == 0) grow_pct = 50;

      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, 1) ? KIND_DELETE : KIND_INSERT;
        s = slot_t'($urandom_range(0, SLOTS - 1));
      end else if ($urandom_range(1, 100) <= grow_pct) begin
        k   = KIND_INSERT;
        idx = $urandom_range(0, live_cnt);
        s   = (idx == live_cnt) ? slot_t'(0) : live_list[idx];
      end else begin
        k = KIND_DELETE;
        if (live_cnt == 0) s = slot_t'($urandom_range(0, SLOTS - 1));
        else s = live_list[$urandom_range(0, live_cnt - 1)];
      end
      send(mk_req(k, s, $urandom));
    end
    in_valid <= 1'b0;

    // let the checker record the last transfer, then drain all replies
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/alle_pkg.sv
sv/alle_ram.sv
sv/alle_free_find.sv
sv/array_linked_list_engine.sv
sim/list_reply_checker.sv
sim/array_linked_list_engine_test.sv
